// ----- rtl/tllc_pkg.sv -----
`timescale 1ns / 1ps

package tllc_pkg;

	// Cache geometry.
	localparam int CACHE_WAYS = 4;
	localparam int TILE_SIZE  = 64;
	localparam int WAY_W      = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
	localparam int FILL_W     = $clog2(CACHE_WAYS + 1);
	localparam int TILE_SHIFT = $clog2(TILE_SIZE);
	localparam int IDX_W      = 2 * TILE_SHIFT;

	// Field widths.
	localparam int COORD_W = 32;
	localparam int TILE_W  = 26;
	localparam int OFF_W   = 17;
	localparam int PB_W    = 6;
	localparam int SLOT_W  = 2;
	localparam int PROD_W  = IDX_W + PB_W;

	// Stream widths.
	localparam int IN_DATA_W  = 2 * COORD_W;
	localparam int OUT_DATA_W = 128;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [PB_W-1:0] PIXEL_BYTES_RST = 6'd4;

	// Item held in the input register: tile coordinates and byte offset.
	typedef struct packed {
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic [OFF_W-1:0]  offset;
	} tile_req_t;

	// Result item.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [TILE_W-1:0] tile_col;
		logic [TILE_W-1:0] tile_row;
		logic [OFF_W-1:0]  byte_offset;
		logic              evict_valid;
		logic [TILE_W-1:0] evict_col;
		logic [TILE_W-1:0] evict_row;
	} tile_res_t;

endpackage

// ----- rtl/tile_lru_lookup_cache.sv -----
`timescale 1ns / 1ps

// Tile lookup cache with least-recently-used replacement. Each item on the slave stream is
// a pixel position; the block subtracts the configured origin (32-bit wrap), splits the
// result into a tile coordinate and an in-tile byte offset, and looks the tile up in a
// four-slot fully associative cache. A hit moves the tile to the front of the recency
// list; a miss fills the next free slot or evicts the least recently used tile, which is
// reported on the result. One item is accepted per clock cycle when the master side keeps
// up; that figure is set by the combinational tag compare and recency update between the
// input register and the result register. An item waits in the input register until the
// result register is free or drained, then moves into it. s_axis_tready follows m_axis_tready
// combinationally when both registers are full. Configuration writes are always accepted
// and must only be made while no item is in flight.

module tile_lru_lookup_cache (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tllc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tllc_pkg::COORD_W-1:0]      cfg_data,
	// Pixel positions in.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [tllc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // pos_x, pos_y
	// Lookup results out.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// slot, tile_col, tile_row, byte_offset, evict_col, evict_row, zero fill
	output logic [tllc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [tllc_pkg::OUT_USER_W-1:0]   m_axis_tuser   // hit, evict_valid
);

	// Configuration registers.
	logic [tllc_pkg::PB_W-1:0]    pixel_bytes_q;
	logic [tllc_pkg::COORD_W-1:0] origin_x_q;
	logic [tllc_pkg::COORD_W-1:0] origin_y_q;

	// Pipeline registers.
	logic                  valid_s1;
	tllc_pkg::tile_req_t   req_s1;
	logic                  out_valid_q;
	tllc_pkg::tile_res_t   res_q;

	// Cache state.
	logic [tllc_pkg::TILE_W-1:0] slot_col_q [tllc_pkg::CACHE_WAYS];
	logic [tllc_pkg::TILE_W-1:0] slot_row_q [tllc_pkg::CACHE_WAYS];
	logic [tllc_pkg::WAY_W-1:0]  order_q    [tllc_pkg::CACHE_WAYS];
	logic [tllc_pkg::FILL_W-1:0] filled_q;

	// Front-end signals.
	logic                         in_accept;
	logic                         advance;
	logic [tllc_pkg::COORD_W-1:0] local_x;
	logic [tllc_pkg::COORD_W-1:0] local_y;
	logic [tllc_pkg::COORD_W-1:0] tile_x_full;
	logic [tllc_pkg::COORD_W-1:0] tile_y_full;
	logic [tllc_pkg::IDX_W-1:0]   pix_idx;
	logic [tllc_pkg::PROD_W-1:0]  pix_prod;
	tllc_pkg::tile_req_t          req_d;

	// Lookup signals.
	logic [tllc_pkg::CACHE_WAYS-1:0] match_pos;
	logic                            hit_c;
	logic [tllc_pkg::WAY_W-1:0]      pos_c;
	logic [tllc_pkg::WAY_W-1:0]      slot_c;
	logic                            evict_c;
	logic [tllc_pkg::WAY_W-1:0]      order_d [tllc_pkg::CACHE_WAYS];
	tllc_pkg::tile_res_t             res_d;

	// Configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bytes_q <= tllc_pkg::PIXEL_BYTES_RST;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tllc_pkg::REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data[tllc_pkg::PB_W-1:0];
				tllc_pkg::REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				tllc_pkg::REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input register moves on when the result register is free or drained.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// Origin removal, floor split into tile and remainder, and in-tile byte offset.
	always_comb begin
		local_x     = s_axis_tdata[tllc_pkg::COORD_W-1:0] - origin_x_q;
		local_y     = s_axis_tdata[tllc_pkg::IN_DATA_W-1:tllc_pkg::COORD_W] - origin_y_q;
		tile_x_full = $unsigned($signed(local_x) >>> tllc_pkg::TILE_SHIFT);
		tile_y_full = $unsigned($signed(local_y) >>> tllc_pkg::TILE_SHIFT);
		pix_idx     = {local_y[tllc_pkg::TILE_SHIFT-1:0], local_x[tllc_pkg::TILE_SHIFT-1:0]};
		pix_prod    = tllc_pkg::PROD_W'(pix_idx) * tllc_pkg::PROD_W'(pixel_bytes_q);
		req_d.col    = tllc_pkg::TILE_W'(tile_x_full);
		req_d.row    = tllc_pkg::TILE_W'(tile_y_full);
		req_d.offset = tllc_pkg::OFF_W'(pix_prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1 <= req_d;
		end
	end

	// Tag compare over the filled positions of the recency list.
	always_comb begin
		for (int i = 0; i < tllc_pkg::CACHE_WAYS; i++) begin
			match_pos[i] = (tllc_pkg::FILL_W'(i) < filled_q)
				&& (slot_col_q[order_q[i]] == req_s1.col)
				&& (slot_row_q[order_q[i]] == req_s1.row);
		end
	end

	// Pick the hit position, else the next free position, else the tail.
	always_comb begin
		hit_c = |match_pos;
		pos_c = '0;
		for (int i = tllc_pkg::CACHE_WAYS - 1; i >= 0; i--) begin
			if (match_pos[i]) begin
				pos_c = tllc_pkg::WAY_W'(i);
			end
		end
		evict_c = 1'b0;
		if (!hit_c) begin
			if (filled_q < tllc_pkg::FILL_W'(tllc_pkg::CACHE_WAYS)) begin
				pos_c = tllc_pkg::WAY_W'(filled_q);
			end else begin
				pos_c   = tllc_pkg::WAY_W'(tllc_pkg::CACHE_WAYS - 1);
				evict_c = 1'b1;
			end
		end
		slot_c = order_q[pos_c];
	end

	// Move the chosen entry to the front of the recency list.
	always_comb begin
		for (int j = 0; j < tllc_pkg::CACHE_WAYS; j++) begin
			if (j == 0) begin
				order_d[j] = slot_c;
			end else if (tllc_pkg::WAY_W'(j) <= pos_c) begin
				order_d[j] = order_q[j-1];
			end else begin
				order_d[j] = order_q[j];
			end
		end
	end

	// Result assembly.
	always_comb begin
		res_d.hit         = hit_c;
		res_d.slot        = tllc_pkg::SLOT_W'(slot_c);
		res_d.tile_col    = req_s1.col;
		res_d.tile_row    = req_s1.row;
		res_d.byte_offset = req_s1.offset;
		res_d.evict_valid = evict_c;
		res_d.evict_col   = evict_c ? slot_col_q[slot_c] : '0;
		res_d.evict_row   = evict_c ? slot_row_q[slot_c] : '0;
	end

	// Recency list and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			for (int j = 0; j < tllc_pkg::CACHE_WAYS; j++) begin
				order_q[j] <= tllc_pkg::WAY_W'(j);
			end
		end else if (advance) begin
			order_q <= order_d;
			if (!hit_c && !evict_c) begin
				filled_q <= filled_q + 1'b1;
			end
		end
	end

	// Tag store written on a miss.
	always_ff @(posedge clk) begin
		if (advance && !hit_c) begin
			slot_col_q[slot_c] <= req_s1.col;
			slot_row_q[slot_c] <= req_s1.row;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Output packing.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {res_q.evict_valid, res_q.hit};
	assign m_axis_tdata  = tllc_pkg::OUT_DATA_W'({res_q.evict_row, res_q.evict_col,
		res_q.byte_offset, res_q.tile_row, res_q.tile_col, res_q.slot});

	// Checks on the cache bookkeeping.
	logic [tllc_pkg::CACHE_WAYS-1:0] slot_listed;

	always_comb begin
		slot_listed = '0;
		for (int j = 0; j < tllc_pkg::CACHE_WAYS; j++) begin
			slot_listed[order_q[j]] = 1'b1;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= tllc_pkg::FILL_W'(tllc_pkg::CACHE_WAYS))
		else $error("fill count beyond cache size");

	a_order_perm: assert property (@(posedge clk) disable iff (!arst_n)
		slot_listed == {tllc_pkg::CACHE_WAYS{1'b1}})
		else $error("recency list is not a permutation of the slots");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !hit_c && !evict_c) |=> (filled_q == $past(filled_q) + 1'b1))
		else $error("miss into a free slot did not grow the fill count");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && evict_c) |-> (!hit_c
			&& filled_q == tllc_pkg::FILL_W'(tllc_pkg::CACHE_WAYS)))
		else $error("eviction without a full cache");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import tllc_pkg::*;

	// Index that decodes to no register; a write to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;

	// Predictor copy of the configuration and the cache state.
	logic [PB_W-1:0] pb_cfg = PIXEL_BYTES_RST;
	logic [COORD_W-1:0] org_x = '0;
	logic [COORD_W-1:0] org_y = '0;
	logic [TILE_W-1:0] tag_col [CACHE_WAYS];
	logic [TILE_W-1:0] tag_row [CACHE_WAYS];
	logic [WAY_W-1:0] mru_list [CACHE_WAYS];
	int n_filled = 0;

	tile_res_t pending_lookups [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	tile_lru_lookup_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the result of one lookup and updates the predicted cache.
	function automatic tile_res_t lookup_tile(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		logic [COORD_W-1:0] lx;
		logic [COORD_W-1:0] ly;
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
		logic [IDX_W-1:0] pix_idx;
		logic [PROD_W-1:0] prod;
		logic [WAY_W-1:0] slot_id;
		tile_res_t r;
		int pos;
		bit found;
		lx = px - org_x;
		ly = py - org_y;
		// Floor division by the tile size is the arithmetic shift of the local coordinate.
		col = lx[COORD_W-1:TILE_SHIFT];
		row = ly[COORD_W-1:TILE_SHIFT];
		pix_idx = {ly[TILE_SHIFT-1:0], lx[TILE_SHIFT-1:0]};
		prod = PROD_W'(pix_idx) * PROD_W'(pb_cfg);
		r = '0;
		r.tile_col = col;
		r.tile_row = row;
		r.byte_offset = prod[OFF_W-1:0];
		found = 1'b0;
		pos = 0;
		for (int i = 0; i < n_filled; i++) begin
			if (!found && tag_col[mru_list[i]] == col && tag_row[mru_list[i]] == row) begin
				pos = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
		end else if (n_filled < CACHE_WAYS) begin
			pos = n_filled;
			n_filled++;
		end else begin
			// Cache full: the tail of the recency list gives up its slot.
			pos = CACHE_WAYS - 1;
			r.evict_valid = 1'b1;
			r.evict_col = tag_col[mru_list[pos]];
			r.evict_row = tag_row[mru_list[pos]];
		end
		slot_id = mru_list[pos];
		if (!found) begin
			tag_col[slot_id] = col;
			tag_row[slot_id] = row;
		end
		for (int j = pos; j > 0; j--)
			mru_list[j] = mru_list[j - 1];
		mru_list[0] = slot_id;
		r.slot = SLOT_W'(slot_id);
		return r;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PIXEL_BYTES: pb_cfg = val[PB_W-1:0];
			REG_ORIGIN_X: org_x = val;
			REG_ORIGIN_Y: org_y = val;
			default: ;
		endcase
	endtask

	// Writes every register, with junk in the unused bits and to the unused index.
	task automatic apply_config(logic [PB_W-1:0] pb, logic [COORD_W-1:0] ox,
			logic [COORD_W-1:0] oy);
		logic [COORD_W-1:0] junk;
		junk = $urandom;
		write_reg(REG_UNUSED, $urandom);
		write_reg(REG_PIXEL_BYTES, {junk[COORD_W-1:PB_W], pb});
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		cfg_valid <= 1'b0;
	endtask

	// Sends one item; tvalid stays high on return so back-to-back items need no gap.
	task automatic send_pos(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
		if (!steady) begin
			while ($urandom_range(0, 99) < 35) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {py, px};
		do @(posedge clk); while (!s_axis_tready);
		pending_lookups.push_back(lookup_tile(px, py));
	endtask

	// Lets every outstanding item come back, then lets the pipeline empty.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reset configuration: fill, hits at both ends of the list, evict, extremes of the fields.
	task automatic test_reset_defaults();
		send_pos(32'd0, 32'd0);
		send_pos(32'd63, 32'd63);
		send_pos(32'd64, 32'd0);
		send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pos(32'h8000_0000, 32'h8000_0000);
		send_pos(32'd64, 32'd5);
		send_pos(32'hFFFF_FFC0, 32'hFFFF_FFFF);
		drain();
	endtask

	// Origins at the extremes so that the subtraction wraps both ways.
	task automatic test_origin_wrap();
		apply_config(6'd32, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pos(32'd0, 32'd0);
		send_pos(32'h7FFF_FFFF, 32'h8000_0000);
		send_pos(32'h8000_0000, 32'h7FFF_FFFF);
		send_pos(32'hFFFF_FFFF, 32'h0000_0001);
		drain();
	endtask

	// Zero pixel size, and a pixel size large enough to wrap the byte offset.
	task automatic test_pixel_size();
		apply_config(6'd0, 32'd0, 32'd0);
		send_pos(32'd63, 32'd63);
		send_pos(32'd1000, 32'd17);
		drain();
		apply_config(6'd63, 32'd0, 32'd0);
		send_pos(32'd63, 32'd63);
		send_pos(32'd1000, 32'd17);
		drain();
	endtask

	// Streams that revisit a small pool of tiles, mixed with positions from anywhere.
	task automatic test_random_streams();
		logic [TILE_W-1:0] pool_col [8];
		logic [TILE_W-1:0] pool_row [8];
		logic [PB_W-1:0] pb;
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		int pool_n;
		int pick;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					pb = 6'd1;
					ox = 32'h8000_0000;
					oy = 32'h8000_0000;
				end
				1: begin
					pb = 6'd32;
					ox = 32'h7FFF_FFFF;
					oy = 32'h7FFF_FFFF;
				end
				default: begin
					pb = ($urandom_range(0, 9) == 0) ? PB_W'($urandom_range(0, 63))
						: PB_W'($urandom_range(1, 32));
					ox = $urandom;
					oy = $urandom;
				end
			endcase
			apply_config(pb, ox, oy);
			steady = (phase == 3);
			// A pool of up to four tiles fits the cache; a larger one forces evictions.
			pool_n = $urandom_range(2, 8);
			for (int k = 0; k < pool_n; k++) begin
				pool_col[k] = $urandom_range(0, 1) ? TILE_W'($urandom_range(0, 6)) - TILE_W'(3)
					: TILE_W'($urandom);
				pool_row[k] = $urandom_range(0, 1) ? TILE_W'($urandom_range(0, 6)) - TILE_W'(3)
					: TILE_W'($urandom);
			end
			for (int n = 0; n < 125; n++) begin
				if ($urandom_range(0, 99) < 80) begin
					pick = $urandom_range(0, pool_n - 1);
					send_pos(ox + {pool_col[pick], TILE_SHIFT'($urandom)},
						oy + {pool_row[pick], TILE_SHIFT'($urandom)});
				end else begin
					send_pos($urandom, $urandom);
				end
			end
			drain();
		end
		steady = 1'b0;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Result side back-pressure.
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
	end

	// Result checking and the stall watchdog.
	always @(posedge clk) begin
		tile_res_t want;
		tile_res_t got;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.hit = m_axis_tuser[0];
			got.evict_valid = m_axis_tuser[1];
			got.slot = m_axis_tdata[1:0];
			got.tile_col = m_axis_tdata[27:2];
			got.tile_row = m_axis_tdata[53:28];
			got.byte_offset = m_axis_tdata[70:54];
			got.evict_col = m_axis_tdata[96:71];
			got.evict_row = m_axis_tdata[122:97];
			if (pending_lookups.size() == 0) begin
				$display("%0t result item with none expected: actual %h", $time, m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_lookups.pop_front();
				check_field("hit", 32'(want.hit), 32'(got.hit));
				check_field("slot", 32'(want.slot), 32'(got.slot));
				check_field("tile_col", 32'(want.tile_col), 32'(got.tile_col));
				check_field("tile_row", 32'(want.tile_row), 32'(got.tile_row));
				check_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
				check_field("evict_valid", 32'(want.evict_valid), 32'(got.evict_valid));
				check_field("evict_col", 32'(want.evict_col), 32'(got.evict_col));
				check_field("evict_row", 32'(want.evict_row), 32'(got.evict_row));
			end
		end
	end

	initial begin
		for (int i = 0; i < CACHE_WAYS; i++) begin
			tag_col[i] = '0;
			tag_row[i] = '0;
			mru_list[i] = WAY_W'(i);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_origin_wrap();
		test_pixel_size();
		test_random_streams();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/tllc_pkg.sv
rtl/tile_lru_lookup_cache.sv
bench/tb.sv
